// ===== sv/adcf_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and types for the ADC DC-block / low-pass / gain block.
// No dependencies; every other file but adcf_chk refers to it by scoped names.
package adcf_pkg;

   localparam int ADC_BITS = 12;
   localparam int FRAC     = 16;
   localparam int RAW_W    = 16;
   localparam int OUT_W    = 16;
   localparam int CW       = 16;                 // coefficient width, Q0.16 / Q8.8
   localparam int CNT_W    = $clog2(CW);
   localparam int XW       = ADC_BITS + FRAC;    // sample << 16, DC estimate
   localparam int DW       = XW + 1;             // centered sample, signed
   localparam int LW       = XW + 2;             // low-pass state, signed
   localparam int MW       = LW + 1;             // multiplicand, signed
   localparam int PW       = MW + 1;             // partial product accumulator
   localparam int GN_SHIFT = 8;                  // rest of the 2^24 after the serial >> 16
   localparam int QW       = PW - GN_SHIFT;      // scaled output before clamping

   localparam int SAT_MAX = 32767;
   localparam int SAT_MIN = -32768;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_DC_RATE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOWPASS_ALPHA = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_GAIN   = 2'd2;

   localparam logic [CW-1:0] DC_RATE_RST       = 16'd66;
   localparam logic [CW-1:0] LOWPASS_ALPHA_RST = 16'd32113;
   localparam logic [CW-1:0] OUTPUT_GAIN_RST   = 16'd15360;

   typedef struct packed {
      logic [CW-1:0] dc_rate;
      logic [CW-1:0] lowpass_alpha;
      logic [CW-1:0] output_gain;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic sticky;
   } mul_stat_type;

   typedef struct packed {
      logic [OUT_W-1:0] filtered_sample;
      logic             clipped;
   } res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DC_GO,
      ST_DC_RUN,
      ST_LP_GO,
      ST_LP_RUN,
      ST_GN_GO,
      ST_GN_RUN,
      ST_OUT
   } state_type;

endpackage

// ===== sv/adcf_smul.sv =====
`timescale 1ns / 1ps
// Bit-serial multiplier: signed multiplicand times unsigned 16-bit coefficient,
// one coefficient bit per cycle, result floor(a*b / 2^16). Uses adcf_pkg.
module adcf_smul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [adcf_pkg::MW-1:0]    op_a,
   input  logic        [adcf_pkg::CW-1:0]    op_b,
   output adcf_pkg::mul_stat_type            stat,
   output logic signed [adcf_pkg::PW-1:0]    prod
);

   logic signed [adcf_pkg::MW-1:0]  a_ff, a_in;
   logic        [adcf_pkg::CW-1:0]  b_ff, b_in;
   logic signed [adcf_pkg::PW-1:0]  p_ff, p_in;
   logic                            sticky_ff, sticky_in;
   logic        [adcf_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic signed [adcf_pkg::PW-1:0]  addend;
   logic signed [adcf_pkg::PW-1:0]  sum;

   always_comb begin
      addend    = b_ff[0] ? adcf_pkg::PW'(a_ff) : '0;
      sum       = p_ff + addend;
      a_in      = a_ff;
      b_in      = b_ff;
      p_in      = p_ff;
      sticky_in = sticky_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         a_in      = op_a;
         b_in      = op_b;
         p_in      = '0;
         sticky_in = 1'b0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         // add this bit's partial product, then drop one bit off the bottom
         p_in      = sum >>> 1;
         sticky_in = sticky_ff | sum[0];
         b_in      = b_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == adcf_pkg::CNT_W'(adcf_pkg::CW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      p_ff      <= p_in;
      sticky_ff <= sticky_in;
      cnt_ff    <= cnt_in;
   end

   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;
   assign stat.sticky = sticky_ff;
   assign prod        = p_ff;

endmodule

// ===== sv/adcf_core.sv =====
`timescale 1ns / 1ps
// Sequencer and filter state: DC estimate, low-pass state, gain and clamp.
// Shares one adcf_smul for all three products. Uses adcf_pkg.
module adcf_core (
   input  logic                          clock,
   input  logic                          reset,
   input  adcf_pkg::cfg_type             cfg,
   input  logic                          in_take,
   input  logic [adcf_pkg::RAW_W-1:0]    raw_word,
   input  logic                          restart,
   output logic                          idle,
   output logic                          res_valid,
   input  logic                          res_take,
   output adcf_pkg::res_type             res
);

   localparam logic signed [adcf_pkg::QW-1:0] QMax = adcf_pkg::QW'(adcf_pkg::SAT_MAX);
   localparam logic signed [adcf_pkg::QW-1:0] QMin = adcf_pkg::QW'(adcf_pkg::SAT_MIN);

   adcf_pkg::state_type               state_ff, state_in;
   logic        [adcf_pkg::XW-1:0]    x_ff, x_in;
   logic        [adcf_pkg::XW-1:0]    dc_ff, dc_in;
   logic                              seeded_ff, seeded_in;
   logic signed [adcf_pkg::LW-1:0]    lp_ff, lp_in;
   logic signed [adcf_pkg::QW-1:0]    q_ff, q_in;

   logic        [adcf_pkg::XW-1:0]    x_new;
   logic signed [adcf_pkg::DW-1:0]    cen;
   logic                              mul_start;
   logic signed [adcf_pkg::MW-1:0]    op_a;
   logic        [adcf_pkg::CW-1:0]    op_b;
   adcf_pkg::mul_stat_type            mstat;
   logic signed [adcf_pkg::PW-1:0]    prod;
   logic                              neg_round;

   adcf_smul u_smul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (op_a),
      .op_b  (op_b),
      .stat  (mstat),
      .prod  (prod)
   );

   always_comb begin
      x_new     = {raw_word[adcf_pkg::ADC_BITS-1:0], adcf_pkg::FRAC'(0)};
      cen       = $signed({1'b0, x_ff}) - $signed({1'b0, dc_ff});
      neg_round = prod[adcf_pkg::PW-1] &
                  (mstat.sticky | (prod[adcf_pkg::GN_SHIFT-1:0] != '0));
      state_in  = state_ff;
      x_in      = x_ff;
      dc_in     = dc_ff;
      seeded_in = seeded_ff;
      lp_in     = lp_ff;
      q_in      = q_ff;
      mul_start = 1'b0;
      op_a      = '0;
      op_b      = '0;
      idle      = 1'b0;
      res_valid = 1'b0;
      res.filtered_sample = q_ff[adcf_pkg::OUT_W-1:0];
      res.clipped         = 1'b0;
      if (q_ff > QMax) begin
         res.filtered_sample = QMax[adcf_pkg::OUT_W-1:0];
         res.clipped         = 1'b1;
      end else if (q_ff < QMin) begin
         res.filtered_sample = QMin[adcf_pkg::OUT_W-1:0];
         res.clipped         = 1'b1;
      end
      unique case (state_ff)
         adcf_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (in_take) begin
               x_in = x_new;
               // seed from this sample on the first item or on restart
               if (restart || !seeded_ff) begin
                  dc_in     = x_new;
                  seeded_in = 1'b1;
               end
               state_in = adcf_pkg::ST_DC_GO;
            end
         end
         adcf_pkg::ST_DC_GO: begin
            mul_start = 1'b1;
            op_a      = adcf_pkg::MW'(cen);
            op_b      = cfg.dc_rate;
            state_in  = adcf_pkg::ST_DC_RUN;
         end
         adcf_pkg::ST_DC_RUN: begin
            if (mstat.done) begin
               dc_in    = dc_ff + prod[adcf_pkg::XW-1:0];
               state_in = adcf_pkg::ST_LP_GO;
            end
         end
         adcf_pkg::ST_LP_GO: begin
            mul_start = 1'b1;
            op_a      = adcf_pkg::MW'(cen) - adcf_pkg::MW'(lp_ff);
            op_b      = cfg.lowpass_alpha;
            state_in  = adcf_pkg::ST_LP_RUN;
         end
         adcf_pkg::ST_LP_RUN: begin
            if (mstat.done) begin
               lp_in    = lp_ff + prod[adcf_pkg::LW-1:0];
               state_in = adcf_pkg::ST_GN_GO;
            end
         end
         adcf_pkg::ST_GN_GO: begin
            mul_start = 1'b1;
            op_a      = adcf_pkg::MW'(lp_ff);
            op_b      = cfg.output_gain;
            state_in  = adcf_pkg::ST_GN_RUN;
         end
         adcf_pkg::ST_GN_RUN: begin
            if (mstat.done) begin
               // floor to 2^24, then step toward zero for negative inexact values
               q_in     = adcf_pkg::QW'(prod >>> adcf_pkg::GN_SHIFT)
                          + adcf_pkg::QW'(neg_round);
               state_in = adcf_pkg::ST_OUT;
            end
         end
         adcf_pkg::ST_OUT: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = adcf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = adcf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= adcf_pkg::ST_IDLE;
         dc_ff     <= '0;
         seeded_ff <= 1'b0;
         lp_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         dc_ff     <= dc_in;
         seeded_ff <= seeded_in;
         lp_ff     <= lp_in;
      end
      x_ff <= x_in;
      q_ff <= q_in;
   end

endmodule

// ===== sv/adc_dc_block_lowpass_gain.sv =====
`timescale 1ns / 1ps
// Top level: ports, configuration registers and the result output register.
// Instantiates adcf_core; uses adcf_pkg.
//
//   group   dir  fields (tdata / tuser, lowest bit first)
//   req_    in   tdata: raw_word[15:0]          tuser: restart
//   rsp_    out  tdata: filtered_sample[15:0]   tuser: clipped
//   csr_    in   index 0 dc_rate, 1 lowpass_alpha, 2 output_gain
//
// When the output is free, an accepted item makes three passes through the bit-serial
// multiplier (start, 16 bit steps, write back) and is then handed off to the output register,
// which raises rsp_tvalid. The next item is taken the cycle after the hand-off, so only one
// item is in flight in the core, while the previous result may still wait in the output
// register; if it still waits when the next result is ready, the core holds that result and
// the input stays closed until the output frees.
// Sync reset clears filter state, seed flag and rsp_tvalid; config registers take reset values.
module adc_dc_block_lowpass_gain (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,   // raw_word[15:0]
   input  logic                             req_tuser,   // restart
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // filtered_sample[15:0]
   output logic                             rsp_tuser,   // clipped
   input  logic                             csr_we,
   input  logic [adcf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [adcf_pkg::CW-1:0]          csr_wdata
);

   adcf_pkg::cfg_type   cfg_ff, cfg_in;
   adcf_pkg::res_type   res;
   logic                idle;
   logic                res_valid;
   logic                res_take;
   logic                in_take;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;

   adcf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_take   (in_take),
      .raw_word  (req_tdata),
      .restart   (req_tuser),
      .idle      (idle),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   always_comb begin
      req_tready = idle & ~reset;
      in_take    = req_tvalid & req_tready;
      res_take   = res_valid & (~rsp_valid_ff | rsp_tready);

      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            adcf_pkg::REG_DC_RATE:       cfg_in.dc_rate       = csr_wdata;
            adcf_pkg::REG_LOWPASS_ALPHA: cfg_in.lowpass_alpha = csr_wdata;
            adcf_pkg::REG_OUTPUT_GAIN:   cfg_in.output_gain   = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.filtered_sample;
         rsp_user_in  = res.clipped;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dc_rate       <= adcf_pkg::DC_RATE_RST;
         cfg_ff.lowpass_alpha <= adcf_pkg::LOWPASS_ALPHA_RST;
         cfg_ff.output_gain   <= adcf_pkg::OUTPUT_GAIN_RST;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== sv/adcf_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for adc_dc_block_lowpass_gain, attached by bind.
// Watches the stream ports only; no package needed.
module adcf_chk (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [15:0]                      req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [15:0]                      rsp_tdata,
   input  logic                             rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // hold a waiting input item
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("waiting input item changed");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // one item at a time: busy right after an accept
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again while an item is in flight");

   // a clipped item always sits at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 16'h7FFF || rsp_tdata == 16'h8000)
      else $error("clipped flag without a saturated value");

endmodule

bind adc_dc_block_lowpass_gain adcf_chk u_adcf_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
